// File: hw/rtl/vurp_pkg.sv
`timescale 1ns / 1ps
// Shared codes, widths and constants for the video unit register port.
package vurp_pkg;

  // Access kinds on the request tuser field
  localparam logic [3:0] KIND_CTRL     = 4'd0;
  localparam logic [3:0] KIND_MASK     = 4'd1;
  localparam logic [3:0] KIND_STATUS   = 4'd2;
  localparam logic [3:0] KIND_SPR_ADDR = 4'd3;
  localparam logic [3:0] KIND_SPR_DATA = 4'd4;
  localparam logic [3:0] KIND_SCROLL   = 4'd5;
  localparam logic [3:0] KIND_ADDR     = 4'd6;
  localparam logic [3:0] KIND_DATA     = 4'd7;
  localparam logic [3:0] KIND_FLAGS    = 4'd8;

  localparam int unsigned VIDEO_DEPTH_DEF = 16384;
  localparam int unsigned SPRITE_DEPTH    = 256;
  localparam int unsigned SPRITE_AW       = $clog2(SPRITE_DEPTH);

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic [15:0] ADDR_STEP_ROW  = 16'd32;
  localparam logic [15:0] ADDR_STEP_ONE  = 16'd1;
  localparam logic [15:0] ADDR_HIGH_MASK = 16'hFF00;
  localparam logic [15:0] ADDR_LOW_MASK  = 16'h00FF;
  localparam logic [7:0]  LAST_LOW_MASK  = 8'h1F;

  // Result fields except the readback byte, which comes from a registered memory read
  typedef struct packed {
    logic [7:0]  status_byte;
    logic [1:0]  nametable_select;
    logic        sprite_table_high;
    logic        background_table_high;
    logic        tall_sprites;
    logic        nmi_enable;
    logic [7:0]  hscroll;
    logic [7:0]  vscroll;
    logic [15:0] video_address;
  } view_t;

endpackage

// File: hw/rtl/video_unit_register_port_unit.sv
`timescale 1ns / 1ps
// Top level: CPU register port of the video unit with video and sprite memories.
//
// One request is taken per cycle unless the output is held back; the rate is set by the
// register update and the registered read of the video and sprite memories, and each
// result leaves through the request stage and the output register. A request stage and an
// output register let one more request enter while a result waits to be taken. VIDEO_DEPTH
// must be a power of two; video memory is addressed by the low bits of the video address.
// Memory contents are undefined until written; no clearing pass is made.
module video_unit_register_port_unit #(
  parameter int unsigned VIDEO_DEPTH = vurp_pkg::VIDEO_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] data, [8] vblank_in, [9] sprite_hit_in, [10] sprite_overflow_in, [15:11] zero
  input  logic [vurp_pkg::IN_DATA_W-1:0]  in_tdata,
  // [3:0] kind
  input  logic [3:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] status_byte, [8] readback_valid, [16:9] readback_data, [18:17] nametable_select,
  // [19] sprite_table_high, [20] background_table_high, [21] tall_sprites, [22] nmi_enable,
  // [30:23] horizontal scroll, [38:31] vertical scroll, [54:39] video_address, [55] zero
  output logic [vurp_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned VA_W = $clog2(VIDEO_DEPTH);

  logic [7:0] video_mem [VIDEO_DEPTH];
  logic [7:0] sprite_mem [vurp_pkg::SPRITE_DEPTH];

  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic        low_next_r, low_next_nxt;
  logic        y_next_r, y_next_nxt;
  logic [7:0]  hscroll_r, hscroll_nxt;
  logic [7:0]  vscroll_r, vscroll_nxt;
  logic [7:0]  spr_addr_r, spr_addr_nxt;
  logic [7:0]  last_r, last_nxt;
  logic        vblank_r, vblank_nxt;
  logic        hit_r, hit_nxt;
  logic        ovf_r, ovf_nxt;

  logic [3:0]  kind;
  logic [7:0]  data;
  logic        accept;
  logic        advance;

  logic                          vid_we, vid_re;
  logic [VA_W-1:0]               vid_waddr, vid_raddr;
  logic [7:0]                    vid_rdata_r;
  logic                          spr_we, spr_re;
  logic [vurp_pkg::SPRITE_AW-1:0] spr_waddr, spr_raddr;
  logic [7:0]                    spr_rdata_r;

  vurp_pkg::view_t view;
  logic            rb_valid, rb_sprite;

  logic            s1_valid_r;
  vurp_pkg::view_t s1_view_r;
  logic            s1_rb_valid_r, s1_rb_sprite_r;

  logic            out_valid_r;
  vurp_pkg::view_t out_view_r;
  logic            out_rb_valid_r;
  logic [7:0]      out_rb_data_r;

  assign kind = in_tuser;
  assign data = in_tdata[7:0];

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    ctrl_nxt     = ctrl_r;
    addr_nxt     = addr_r;
    low_next_nxt = low_next_r;
    y_next_nxt   = y_next_r;
    hscroll_nxt  = hscroll_r;
    vscroll_nxt  = vscroll_r;
    spr_addr_nxt = spr_addr_r;
    last_nxt     = last_r;
    vblank_nxt   = vblank_r;
    hit_nxt      = hit_r;
    ovf_nxt      = ovf_r;
    vid_we       = 1'b0;
    vid_re       = 1'b0;
    spr_we       = 1'b0;
    spr_re       = 1'b0;
    rb_valid     = 1'b0;
    rb_sprite    = 1'b0;
    if (accept) begin
      if (kind == vurp_pkg::KIND_CTRL ||
          (kind >= vurp_pkg::KIND_SPR_ADDR && kind <= vurp_pkg::KIND_DATA)) begin
        last_nxt = data;
      end
      unique case (kind)
        vurp_pkg::KIND_CTRL: begin
          ctrl_nxt = data;
        end
        vurp_pkg::KIND_STATUS: begin
          vblank_nxt   = 1'b0;
          y_next_nxt   = 1'b0;
          low_next_nxt = 1'b0;
        end
        vurp_pkg::KIND_SPR_ADDR: begin
          spr_addr_nxt = data;
          spr_re       = 1'b1;
          rb_valid     = 1'b1;
          rb_sprite    = 1'b1;
        end
        vurp_pkg::KIND_SPR_DATA: begin
          spr_we = 1'b1;
        end
        vurp_pkg::KIND_SCROLL: begin
          if (y_next_r) begin
            vscroll_nxt = data;
          end else begin
            hscroll_nxt = data;
          end
          y_next_nxt = !y_next_r;
        end
        vurp_pkg::KIND_ADDR: begin
          if (low_next_r) begin
            addr_nxt = (addr_r & vurp_pkg::ADDR_HIGH_MASK) | {8'd0, data};
            vid_re   = 1'b1;
            rb_valid = 1'b1;
          end else begin
            addr_nxt = (addr_r & vurp_pkg::ADDR_LOW_MASK) | {data, 8'd0};
          end
          low_next_nxt = !low_next_r;
        end
        vurp_pkg::KIND_DATA: begin
          vid_we   = 1'b1;
          addr_nxt = addr_r + (ctrl_r[2] ? vurp_pkg::ADDR_STEP_ROW : vurp_pkg::ADDR_STEP_ONE);
        end
        vurp_pkg::KIND_FLAGS: begin
          vblank_nxt = in_tdata[8];
          hit_nxt    = in_tdata[9];
          ovf_nxt    = in_tdata[10];
        end
        default: begin
        end
      endcase
    end
  end

  assign vid_waddr = addr_r[VA_W-1:0];
  assign vid_raddr = addr_nxt[VA_W-1:0];
  assign spr_waddr = spr_addr_r[vurp_pkg::SPRITE_AW-1:0];
  assign spr_raddr = data[vurp_pkg::SPRITE_AW-1:0];

  // Only one request touches memory per cycle, so a read never meets a same-cycle write
  always_ff @(posedge clk) begin
    if (vid_we) begin
      video_mem[vid_waddr] <= data;
    end
    if (vid_re) begin
      vid_rdata_r <= video_mem[vid_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (spr_we) begin
      sprite_mem[spr_waddr] <= data;
    end
    if (spr_re) begin
      spr_rdata_r <= sprite_mem[spr_raddr];
    end
  end

  always_comb begin
    view.status_byte           = {vblank_nxt, hit_nxt, ovf_nxt,
                                  last_nxt[4:0] & vurp_pkg::LAST_LOW_MASK[4:0]};
    view.nametable_select      = ctrl_nxt[1:0];
    view.sprite_table_high     = ctrl_nxt[3];
    view.background_table_high = ctrl_nxt[4];
    view.tall_sprites          = ctrl_nxt[5];
    view.nmi_enable            = ctrl_nxt[7];
    view.hscroll               = hscroll_nxt;
    view.vscroll               = vscroll_nxt;
    view.video_address         = addr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r     <= '0;
      addr_r     <= '0;
      low_next_r <= 1'b0;
      y_next_r   <= 1'b0;
      hscroll_r  <= '0;
      vscroll_r  <= '0;
      spr_addr_r <= '0;
      last_r     <= '0;
      vblank_r   <= 1'b0;
      hit_r      <= 1'b0;
      ovf_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ctrl_r     <= ctrl_nxt;
      addr_r     <= addr_nxt;
      low_next_r <= low_next_nxt;
      y_next_r   <= y_next_nxt;
      hscroll_r  <= hscroll_nxt;
      vscroll_r  <= vscroll_nxt;
      spr_addr_r <= spr_addr_nxt;
      last_r     <= last_nxt;
      vblank_r   <= vblank_nxt;
      hit_r      <= hit_nxt;
      ovf_r      <= ovf_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload stages; memory read data stays put until the next accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_view_r      <= view;
      s1_rb_valid_r  <= rb_valid;
      s1_rb_sprite_r <= rb_sprite;
    end
    if (advance && s1_valid_r) begin
      out_view_r     <= s1_view_r;
      out_rb_valid_r <= s1_rb_valid_r;
      if (!s1_rb_valid_r) begin
        out_rb_data_r <= '0;
      end else if (s1_rb_sprite_r) begin
        out_rb_data_r <= spr_rdata_r;
      end else begin
        out_rb_data_r <= vid_rdata_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0,
                       out_view_r.video_address,
                       out_view_r.vscroll,
                       out_view_r.hscroll,
                       out_view_r.nmi_enable,
                       out_view_r.tall_sprites,
                       out_view_r.background_table_high,
                       out_view_r.sprite_table_high,
                       out_view_r.nametable_select,
                       out_rb_data_r,
                       out_rb_valid_r,
                       out_view_r.status_byte};

endmodule

// File: dv/vurp_checker.sv
`timescale 1ns / 1ps
// Result checker for the video unit register port: predicts each result and compares it.
module vurp_checker #(
  parameter int unsigned VIDEO_DEPTH = vurp_pkg::VIDEO_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [vurp_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [3:0]                      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [vurp_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                              mismatch_count,
  output int                              pending_views
);

  // out_tdata layout, msb first
  typedef struct packed {
    logic        pad;
    logic [15:0] video_address;
    logic [7:0]  vscroll;
    logic [7:0]  hscroll;
    logic        nmi_enable;
    logic        tall_sprites;
    logic        background_table_high;
    logic        sprite_table_high;
    logic [1:0]  nametable_select;
    logic [7:0]  readback_data;
    logic        readback_valid;
    logic [7:0]  status_byte;
  } port_view_t;

  port_view_t expected_views[$];

  logic [7:0]  video_mem [VIDEO_DEPTH];
  logic [7:0]  sprite_mem [vurp_pkg::SPRITE_DEPTH];
  logic [7:0]  ctrl_reg;
  logic [15:0] vaddr;
  logic        addr_low_next;
  logic        vscroll_next;
  logic [7:0]  hscroll_reg;
  logic [7:0]  vscroll_reg;
  logic [7:0]  spr_ptr;
  logic [7:0]  last_wr;
  logic        vblank;
  logic        hit;
  logic        overflow;

  task automatic predict_access(input logic [3:0] kind, input logic [7:0] data,
                                input logic [2:0] flags, output port_view_t view);
    view = '0;
    if (kind == vurp_pkg::KIND_CTRL ||
        (kind >= vurp_pkg::KIND_SPR_ADDR && kind <= vurp_pkg::KIND_DATA)) last_wr = data;
    case (kind)
      vurp_pkg::KIND_CTRL: ctrl_reg = data;
      vurp_pkg::KIND_STATUS: begin
        vblank = 1'b0;
        vscroll_next = 1'b0;
        addr_low_next = 1'b0;
      end
      vurp_pkg::KIND_SPR_ADDR: begin
        spr_ptr = data;
        view.readback_valid = 1'b1;
        view.readback_data = sprite_mem[data];
      end
      vurp_pkg::KIND_SPR_DATA: sprite_mem[spr_ptr] = data;
      vurp_pkg::KIND_SCROLL: begin
        if (vscroll_next) vscroll_reg = data;
        else hscroll_reg = data;
        vscroll_next = !vscroll_next;
      end
      vurp_pkg::KIND_ADDR: begin
        if (addr_low_next) begin
          vaddr[7:0] = data;
          view.readback_valid = 1'b1;
          view.readback_data = video_mem[vaddr % VIDEO_DEPTH];
        end else begin
          vaddr[15:8] = data;
        end
        addr_low_next = !addr_low_next;
      end
      vurp_pkg::KIND_DATA: begin
        video_mem[vaddr % VIDEO_DEPTH] = data;
        vaddr = vaddr + (ctrl_reg[2] ? vurp_pkg::ADDR_STEP_ROW : vurp_pkg::ADDR_STEP_ONE);
      end
      vurp_pkg::KIND_FLAGS: {overflow, hit, vblank} = flags;
      default: ;
    endcase
    view.status_byte = {vblank, hit, overflow, last_wr[4:0]};
    view.nametable_select = ctrl_reg[1:0];
    view.sprite_table_high = ctrl_reg[3];
    view.background_table_high = ctrl_reg[4];
    view.tall_sprites = ctrl_reg[5];
    view.nmi_enable = ctrl_reg[7];
    view.hscroll = hscroll_reg;
    view.vscroll = vscroll_reg;
    view.video_address = vaddr;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    port_view_t got;
    port_view_t want;
    if (!rst_n) begin
      ctrl_reg = '0;
      vaddr = '0;
      addr_low_next = 1'b0;
      vscroll_next = 1'b0;
      hscroll_reg = '0;
      vscroll_reg = '0;
      spr_ptr = '0;
      last_wr = '0;
      vblank = 1'b0;
      hit = 1'b0;
      overflow = 1'b0;
      expected_views.delete();
    end else begin
      // results leave only after their request is registered, so compare before predicting
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_views.size() == 0) begin
          $display("%0t unexpected result: expected none, actual 0x%0h", $time, out_tdata);
          mismatch_count++;
        end else begin
          want = expected_views.pop_front();
          check_field("status_byte", want.status_byte, got.status_byte);
          check_field("readback_valid", want.readback_valid, got.readback_valid);
          check_field("readback_data", want.readback_data, got.readback_data);
          check_field("nametable_select", want.nametable_select, got.nametable_select);
          check_field("sprite_table_high", want.sprite_table_high, got.sprite_table_high);
          check_field("background_table_high", want.background_table_high,
                      got.background_table_high);
          check_field("tall_sprites", want.tall_sprites, got.tall_sprites);
          check_field("nmi_enable", want.nmi_enable, got.nmi_enable);
          check_field("hscroll", want.hscroll, got.hscroll);
          check_field("vscroll", want.vscroll, got.vscroll);
          check_field("video_address", want.video_address, got.video_address);
        end
      end
      if (in_tvalid && in_tready) begin
        predict_access(in_tuser, in_tdata[7:0], in_tdata[10:8], want);
        expected_views.push_back(want);
      end
    end
    pending_views = expected_views.size();
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench top: drives register requests into the video unit register port and reports.
module tb;

  localparam int unsigned VDEPTH = vurp_pkg::VIDEO_DEPTH_DEF;
  localparam int N_ACCESSES = 550;
  localparam int IDLE_LIMIT = 1000;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int RX_HOLD_AT = 150;
  localparam logic [3:0] KIND_UNUSED_LO = 4'd9;
  localparam logic [3:0] KIND_UNUSED_HI = 4'd15;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic [vurp_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [3:0]                      in_tuser = '0;
  logic                            out_tready = 1'b0;
  logic                            in_tready;
  logic                            out_tvalid;
  logic [vurp_pkg::OUT_DATA_W-1:0] out_tdata;
  int                              mismatch_count;
  int                              pending_views;

  // shadow of the address state, so that memory reads only hit written entries
  logic        step_row = 1'b0;
  logic [15:0] vaddr_sh = '0;
  logic        addr_low_next_sh = 1'b0;
  logic [7:0]  spr_ptr_sh = '0;
  bit          video_written [VDEPTH];
  bit          sprite_written [vurp_pkg::SPRITE_DEPTH];
  int unsigned video_written_q[$];
  int unsigned sprite_written_q[$];
  int          tx_calm = 0;
  int          issued = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  video_unit_register_port_unit #(.VIDEO_DEPTH(VDEPTH)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  vurp_checker #(.VIDEO_DEPTH(VDEPTH)) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .pending_views  (pending_views)
  );

  // idle cycles before the next request; now and then a stretch with none
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  task automatic send_access(input logic [3:0] kind, input logic [7:0] data,
                             input logic [2:0] flags);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {5'b0, flags, data};
    do @(posedge clk); while (!in_tready);
    case (kind)
      vurp_pkg::KIND_CTRL: step_row = data[2];
      vurp_pkg::KIND_STATUS: addr_low_next_sh = 1'b0;
      vurp_pkg::KIND_SPR_ADDR: spr_ptr_sh = data;
      vurp_pkg::KIND_SPR_DATA: begin
        if (!sprite_written[spr_ptr_sh]) begin
          sprite_written[spr_ptr_sh] = 1'b1;
          sprite_written_q.push_back(32'(spr_ptr_sh));
        end
      end
      vurp_pkg::KIND_ADDR: begin
        if (addr_low_next_sh) vaddr_sh[7:0] = data;
        else vaddr_sh[15:8] = data;
        addr_low_next_sh = !addr_low_next_sh;
      end
      vurp_pkg::KIND_DATA: begin
        if (!video_written[vaddr_sh % VDEPTH]) begin
          video_written[vaddr_sh % VDEPTH] = 1'b1;
          video_written_q.push_back(vaddr_sh % VDEPTH);
        end
        vaddr_sh = vaddr_sh + (step_row ? vurp_pkg::ADDR_STEP_ROW : vurp_pkg::ADDR_STEP_ONE);
      end
      default: ;
    endcase
    if (kind != vurp_pkg::KIND_MASK && kind <= vurp_pkg::KIND_FLAGS) issued++;
  endtask

  // steers requests that read memory onto written entries
  task automatic send_checked(input logic [3:0] kind, input logic [7:0] data,
                              input logic [2:0] flags);
    logic [3:0]  k;
    logic [7:0]  d;
    int unsigned base;
    bit          found;
    k = kind;
    d = data;
    if (kind == vurp_pkg::KIND_SPR_ADDR && !sprite_written[data]) begin
      if (sprite_written_q.size() == 0) k = vurp_pkg::KIND_SPR_DATA;
      else d = 8'(sprite_written_q[$urandom_range(0, sprite_written_q.size() - 1)]);
    end else if (kind == vurp_pkg::KIND_ADDR && addr_low_next_sh &&
                 !video_written[{vaddr_sh[15:8], data} % VDEPTH]) begin
      found = 1'b0;
      base = $urandom_range(0, 255);
      for (int i = 0; i < 256 && !found; i++) begin
        if (video_written[{vaddr_sh[15:8], 8'(base + i)} % VDEPTH]) begin
          found = 1'b1;
          d = 8'(base + i);
        end
      end
      // nothing written in this page: a status read resets the toggle instead
      if (!found) k = vurp_pkg::KIND_STATUS;
    end
    send_access(k, d, flags);
  endtask

  initial begin : receiver
    int gap;
    int calm;
    int taken;
    calm = 0;
    taken = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      // one long hold lets the port fill up and push back on requests
      gap = (taken == RX_HOLD_AT) ? RX_HOLD_CYCLES : draw_gap(calm);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst_n && !(in_tvalid && in_tready) && !(out_tvalid && out_tready)) idle++;
      else idle = 0;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int unsigned full;
    bit          paused;
    paused = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_access(vurp_pkg::KIND_FLAGS, 8'h00, 3'b111);
    send_access(vurp_pkg::KIND_STATUS, 8'hFF, 3'b000);
    send_access(vurp_pkg::KIND_CTRL, 8'hFF, 3'b000);
    send_access(vurp_pkg::KIND_MASK, 8'hAA, 3'b000);
    send_access(vurp_pkg::KIND_SCROLL, 8'h00, 3'b000);
    send_access(vurp_pkg::KIND_SCROLL, 8'hFF, 3'b000);
    send_access(vurp_pkg::KIND_SPR_DATA, 8'hFF, 3'b000);
    send_checked(vurp_pkg::KIND_SPR_ADDR, 8'h00, 3'b000);
    // row steps from the top page wrap the address through zero
    send_access(vurp_pkg::KIND_ADDR, 8'hFF, 3'b000);
    for (int i = 0; i < 8; i++) begin
      send_access(vurp_pkg::KIND_DATA, (i == 0) ? 8'hFF : 8'(i * 37), 3'b000);
    end
    send_access(vurp_pkg::KIND_STATUS, 8'h00, 3'b000);
    send_access(vurp_pkg::KIND_ADDR, 8'hFF, 3'b000);
    send_checked(vurp_pkg::KIND_ADDR, 8'hE0, 3'b000);
    send_access(KIND_UNUSED_LO, 8'h55, 3'b111);
    send_access(KIND_UNUSED_HI, 8'hFF, 3'b111);
    send_access(vurp_pkg::KIND_CTRL, 8'h00, 3'b000);

    while (issued < N_ACCESSES) begin
      if (!paused && issued >= N_ACCESSES / 2) begin
        paused = 1'b1;
        in_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending_views == 0);
        @(posedge clk);
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          if (addr_low_next_sh) begin
            send_access(vurp_pkg::KIND_STATUS, 8'($urandom), 3'($urandom));
          end
          if (video_written_q.size() > 0 && $urandom_range(0, 1) == 1)
            full = ($urandom & 32'hFFFF & ~(VDEPTH - 1)) |
                   video_written_q[$urandom_range(0, video_written_q.size() - 1)];
          else
            full = $urandom_range(0, 16'hFFFF);
          send_access(vurp_pkg::KIND_ADDR, full[15:8], 3'($urandom));
          send_checked(vurp_pkg::KIND_ADDR, full[7:0], 3'($urandom));
          repeat ($urandom_range(1, 8)) begin
            send_access(vurp_pkg::KIND_DATA, 8'($urandom), 3'($urandom));
          end
        end
        3, 4: begin
          if (video_written_q.size() > 0) begin
            if (addr_low_next_sh) begin
              send_access(vurp_pkg::KIND_STATUS, 8'($urandom), 3'($urandom));
            end
            full = ($urandom & 32'hFFFF & ~(VDEPTH - 1)) |
                   video_written_q[$urandom_range(0, video_written_q.size() - 1)];
            send_access(vurp_pkg::KIND_ADDR, full[15:8], 3'($urandom));
            send_checked(vurp_pkg::KIND_ADDR, full[7:0], 3'($urandom));
          end
        end
        5: begin
          send_access(vurp_pkg::KIND_SCROLL, 8'($urandom), 3'($urandom));
          if ($urandom_range(0, 3) == 0) begin
            send_access(vurp_pkg::KIND_STATUS, 8'($urandom), 3'($urandom));
          end
          send_access(vurp_pkg::KIND_SCROLL, 8'($urandom), 3'($urandom));
        end
        6: send_access(vurp_pkg::KIND_CTRL, 8'($urandom), 3'($urandom));
        7: begin
          send_access(vurp_pkg::KIND_SPR_DATA, 8'($urandom), 3'($urandom));
          send_checked(vurp_pkg::KIND_SPR_ADDR, 8'($urandom), 3'($urandom));
        end
        8: begin
          send_access(vurp_pkg::KIND_FLAGS, 8'($urandom), 3'($urandom));
          if ($urandom_range(0, 1) == 1) begin
            send_access(vurp_pkg::KIND_STATUS, 8'($urandom), 3'($urandom));
          end
        end
        default: begin
          repeat ($urandom_range(1, 4)) begin
            send_checked(4'($urandom_range(0, 15)), 8'($urandom), 3'($urandom));
          end
        end
      endcase
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending_views == 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/vurp_pkg.sv
hw/rtl/video_unit_register_port_unit.sv
dv/vurp_checker.sv
dv/tb.sv
